// ----- hw/rtl/rat_pkg.sv -----
`default_nettype none
package rat_pkg;

  localparam int unsigned MAX_REGIONS = 16;
  localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW    = 32;
  localparam int unsigned EIW   = 4;
  localparam int unsigned ARW   = 5;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [EIW-1:0]  idx;
    logic [AW-1:0]   base;
    logic [AW-1:0]   size;
    logic [AW-1:0]   offset;
    logic [AW-1:0]   addr;
  } req_t;

  typedef struct packed {
    logic [AW-1:0] base;
    logic [AW-1:0] size;
    logic [AW-1:0] offset;
  } entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rat_if.sv -----
`default_nettype none
interface rat_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  entry_index;
  logic [31:0] entry_base;
  logic [31:0] entry_size;
  logic [31:0] entry_file_offset;
  logic [31:0] address;

  modport source (output valid, action, entry_index, entry_base, entry_size,
                  entry_file_offset, address, input ready);
  modport sink   (input valid, action, entry_index, entry_base, entry_size,
                  entry_file_offset, address, output ready);
endinterface

interface rat_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_offset;
  logic        hit;

  modport source (output valid, file_offset, hit, input ready);
  modport sink   (input valid, file_offset, hit, output ready);
endinterface

interface rat_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rat_front.sv -----
`default_nettype none
module rat_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  rat_in_if.sink             in_chan,
  output rat_pkg::req_t      q_item_o,
  output logic               q_valid_o,
  input  wire logic          q_pop_i
);
  import rat_pkg::*;

  // two-entry request queue toward the table engine
  req_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  req_t       req;

  always_comb begin
    req.op     = in_chan.action ? OP_LOOKUP : OP_WRITE;
    req.idx    = in_chan.entry_index;
    req.base   = in_chan.entry_base;
    req.size   = in_chan.entry_size;
    req.offset = in_chan.entry_file_offset;
    req.addr   = in_chan.address;
  end

  assign in_chan.ready = (count_q != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid_o     = (count_q != 2'd0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_item_o      = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= req;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rat_back.sv -----
`default_nettype none
module rat_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rat_pkg::req_t q_item_i,
  input  wire logic          q_valid_i,
  output logic               q_pop_o,
  rat_cfg_if.sink            cfg_chan,
  rat_out_if.source          out_chan
);
  import rat_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  entry_t             mem_q [MAX_REGIONS];
  entry_t             rdata_q;
  logic [1:0]         state_q, state_d;
  logic [ARW-1:0]     active_q;
  logic [AW-1:0]      addr_q;
  logic [CNT_W-1:0]   lim_q, lim_d;
  logic [CNT_W-1:0]   rd_cnt_q;
  logic               rvalid_q, rlast_q;
  logic               res_hit_q;
  logic [AW-1:0]      diff_q, off_q;
  logic               ovalid_q;
  logic [AW-1:0]      ofs_q;
  logic               ohit_q;
  logic               wr_en, rd_en, match, out_free;
  logic [AW-1:0]      end_addr;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_chan.valid) begin
      active_q <= cfg_chan.data;
    end
  end

  // scan length saturates at the table depth
  always_comb begin
    if (32'(active_q) > 32'(MAX_REGIONS)) begin
      lim_d = CNT_W'(MAX_REGIONS);
    end else begin
      lim_d = CNT_W'(active_q);
    end
  end

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign wr_en    = q_pop_o && (q_item_i.op == OP_WRITE) &&
                    (32'(q_item_i.idx) < 32'(MAX_REGIONS));
  assign end_addr = rdata_q.base + rdata_q.size;
  assign match    = rvalid_q && (rdata_q.base <= addr_q) && (end_addr > addr_q);
  assign rd_en    = (state_q == ST_SCAN) && (rd_cnt_q < lim_q) && !match;
  assign out_free = !ovalid_q || out_chan.ready;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[IDX_W'(q_item_i.idx)] <= '{base:   q_item_i.base,
                                       size:   q_item_i.size,
                                       offset: q_item_i.offset};
    end
    if (rd_en) begin
      rdata_q <= mem_q[IDX_W'(rd_cnt_q)];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o && (q_item_i.op == OP_LOOKUP)) begin
          state_d = (lim_d == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || (rvalid_q && rlast_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lim_q     <= '0;
      rd_cnt_q  <= '0;
      rvalid_q  <= 1'b0;
      rlast_q   <= 1'b0;
      res_hit_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        lim_q     <= lim_d;
        rd_cnt_q  <= '0;
        rvalid_q  <= 1'b0;
        res_hit_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        rvalid_q <= rd_en;
        if (rd_en) begin
          rd_cnt_q <= rd_cnt_q + CNT_W'(1);
          rlast_q  <= (rd_cnt_q == lim_q - CNT_W'(1));
        end
        if (match) begin
          res_hit_q <= 1'b1;
        end
      end
      if ((state_q == ST_DONE) && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_chan.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      addr_q <= q_item_i.addr;
    end
    if (match) begin
      diff_q <= addr_q - rdata_q.base;
      off_q  <= rdata_q.offset;
    end
    if ((state_q == ST_DONE) && out_free) begin
      ofs_q  <= res_hit_q ? (diff_q + off_q) : '0;
      ohit_q <= res_hit_q;
    end
  end

  assign out_chan.valid       = ovalid_q;
  assign out_chan.file_offset = ofs_q;
  assign out_chan.hit         = ohit_q;

endmodule
`default_nettype wire

// ----- hw/rtl/region_address_translate_unit.sv -----
`default_nettype none
// channel   dir  payload                                           handshake
// in_chan   in   action, entry_index, entry_base/size/file_offset, valid/ready
//                address
// out_chan  out  file_offset, hit                                  valid/ready
// cfg_chan  in   data (active_regions)                             valid/ready
//
// A write request lands in the table when the engine takes it from the queue; a
// lookup result is set by the scan, which reads one entry per cycle over the
// table's single read port and stops at the first matching entry.
// A two-deep request queue lets input accept while the engine scans; the
// output register frees the engine while a result waits for ready.
// Reset clears the queue, the engine and active_regions; table contents stay
// undefined until written.
module region_address_translate_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rat_in_if.sink    in_chan,
  rat_out_if.source out_chan,
  rat_cfg_if.sink   cfg_chan
);
  import rat_pkg::*;

  req_t q_item;
  logic q_valid;
  logic q_pop;

  rat_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan   (in_chan),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  rat_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_item_i  (q_item),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .cfg_chan  (cfg_chan),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire
